### rtl/core/odometry_battery_estimator_core_assert.svh
// assertion macros used by the odometry estimator core
`ifndef ODOMETRY_BATTERY_ESTIMATOR_CORE_ASSERT_SVH
`define ODOMETRY_BATTERY_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OBE_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OBE_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/obe_pkg.sv
// shared types and constants for the odometry battery estimator
`timescale 1ns / 1ps

package obe_pkg;

	localparam int CFG_BITS     = 32;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_FULL_RANGE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THRESH = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SQ,
		ST_ROOT,
		ST_ACC,
		ST_REM,
		ST_CHK,
		ST_OUT
	} obe_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} obe_unit_sts_t;

endpackage

### rtl/core/obe_sqr.sv
// serial squarer, two multiplier bits per cycle, msb first
`timescale 1ns / 1ps

module obe_sqr #(
	parameter int W = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          opnd,
	output logic [2*W-1:0]        prod,
	output obe_pkg::obe_unit_sts_t sts
);
	import obe_pkg::*;

	localparam int PW = W + (W % 2);
	localparam int ND = PW / 2;
	localparam int CW = $clog2(ND + 1);

	logic [W-1:0]    a_q;
	logic [PW-1:0]   m_q;
	logic [2*PW-1:0] acc_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [1:0]      dig;
	logic [W+1:0]    pp;

	assign dig = m_q[PW-1:PW-2];
	// operand times one radix-4 digit
	assign pp = ({2'b00, a_q} & {(W+2){dig[0]}}) + ({1'b0, a_q, 1'b0} & {(W+2){dig[1]}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ND - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= opnd;
			m_q   <= PW'(opnd);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[2*PW-3:0], 2'b00} + (2*PW)'(pp);
			m_q   <= {m_q[PW-3:0], 2'b00};
		end
	end

	assign prod     = acc_q[2*W-1:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### rtl/core/obe_isqrt.sv
// serial restoring integer square root, one root bit per cycle
`timescale 1ns / 1ps

module obe_isqrt #(
	parameter int W = 49,
	localparam int NR = (W + 1) / 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          radicand,
	output logic [NR-1:0]         root,
	output obe_pkg::obe_unit_sts_t sts
);
	import obe_pkg::*;

	localparam int RW = 2 * NR;
	localparam int CW = $clog2(NR + 1);

	logic [RW-1:0]   n_q;
	logic [NR-1:0]   root_q;
	logic [NR+1:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NR+3:0]   t;
	logic [NR+3:0]   trial;
	logic            ge;

	// bring down the next pair and try root*4+1
	assign t     = {rem_q, n_q[RW-1:RW-2]};
	assign trial = (NR+4)'({root_q, 2'b01});
	assign ge    = (t >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NR - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= RW'(radicand);
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[RW-3:0], 2'b00};
			root_q <= {root_q[NR-2:0], ge};
			if (ge) begin
				rem_q <= (NR+2)'(t - trial);
			end else begin
				rem_q <= (NR+2)'(t);
			end
		end
	end

	assign root     = root_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### rtl/core/odometry_battery_estimator_core.sv
// Odometry distance accumulator and battery range estimator. Takes one request at a time:
// a position sample that moves the robot reaches the output register after the
// two-bit-per-cycle squarers for dx and dy and then the one-bit-per-cycle square root
// (states PREP, SQ, ROOT, ACC, REM, CHK, OUT); a recharge passes PREP, REM and OUT, and
// the first latched sample or an ignored sample PREP, REM, CHK and OUT. The block returns
// to idle before the next request is taken. A finished result sits in the output
// register, so the next request is taken while it waits; a second finished result keeps the
// input stalled until the first one is taken. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module odometry_battery_estimator_core #(
	parameter int COORD_BITS = 24,
	parameter int DIST_BITS  = 32,
	localparam int REM_BITS  = ((DIST_BITS > obe_pkg::CFG_BITS) ? DIST_BITS
	                            : obe_pkg::CFG_BITS) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic signed [COORD_BITS-1:0]      pos_x,
	input  logic signed [COORD_BITS-1:0]      pos_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [DIST_BITS-1:0]              distance_travelled,
	output logic signed [REM_BITS-1:0]        remaining_range,
	output logic                              low_battery,
	output logic                              tracking,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [obe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [obe_pkg::CFG_BITS-1:0]      cfg_data
);
	import obe_pkg::*;

	`include "odometry_battery_estimator_core_assert.svh"

	localparam int SQ_BITS   = 2 * COORD_BITS;
	localparam int RAD_BITS  = SQ_BITS + 1;
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int ACC_BITS  = ((DIST_BITS > ROOT_BITS) ? DIST_BITS : ROOT_BITS) + 1;

	obe_state_t state_q, state_d;

	logic                         kind_q;
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [DIST_BITS-1:0]         dist_q;
	logic                         armed_q;
	logic                         low_q;
	logic [CFG_BITS-1:0]          full_q, thr_q;
	logic [REM_BITS-1:0]          rem_q;

	logic                         out_valid_q;
	logic [DIST_BITS-1:0]         out_dist_q;
	logic [REM_BITS-1:0]          out_rem_q;
	logic                         out_low_q;
	logic                         out_trk_q;

	logic                         accept;
	logic                         sq_start, root_start, out_load;
	logic                         moving, first_fix;
	logic [COORD_BITS:0]          dx_w, dy_w;
	logic [COORD_BITS-1:0]        dx, dy;
	logic [SQ_BITS-1:0]           sqx, sqy;
	logic [RAD_BITS-1:0]          radicand;
	logic [ROOT_BITS-1:0]         root;
	logic [ACC_BITS-1:0]          sum_w;
	logic                         sat;
	obe_unit_sts_t                sqx_sts, sqy_sts, root_sts;

	assign accept = in_valid && !in_stall;

	assign moving    = !kind_q && !armed_q;
	assign first_fix = !kind_q && armed_q && (x_q != '0) && (y_q != '0);

	// absolute coordinate differences, both orders computed side by side
	assign dx_w = ($signed(x_q) >= $signed(prev_x_q))
		? ({x_q[COORD_BITS-1], x_q} - {prev_x_q[COORD_BITS-1], prev_x_q})
		: ({prev_x_q[COORD_BITS-1], prev_x_q} - {x_q[COORD_BITS-1], x_q});
	assign dy_w = ($signed(y_q) >= $signed(prev_y_q))
		? ({y_q[COORD_BITS-1], y_q} - {prev_y_q[COORD_BITS-1], prev_y_q})
		: ({prev_y_q[COORD_BITS-1], prev_y_q} - {y_q[COORD_BITS-1], y_q});
	assign dx = dx_w[COORD_BITS-1:0];
	assign dy = dy_w[COORD_BITS-1:0];

	assign radicand = {1'b0, sqx} + {1'b0, sqy};

	// saturating distance add
	assign sum_w = ACC_BITS'(dist_q) + ACC_BITS'(root);
	assign sat   = |sum_w[ACC_BITS-1:DIST_BITS];

	obe_sqr #(.W(COORD_BITS)) u_sqr_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.opnd   (dx),
		.prod   (sqx),
		.sts    (sqx_sts)
	);

	obe_sqr #(.W(COORD_BITS)) u_sqr_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.opnd   (dy),
		.prod   (sqy),
		.sts    (sqy_sts)
	);

	obe_isqrt #(.W(RAD_BITS)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.root     (root),
		.sts      (root_sts)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (moving) begin
					state_d = ST_SQ;
				end else begin
					state_d = ST_REM;
				end
			end
			ST_SQ: begin
				if (sqx_sts.done) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_sts.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = ST_REM;
			end
			ST_REM: begin
				if (kind_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		in_stall   = 1'b1;
		sq_start   = 1'b0;
		root_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_PREP: begin
				sq_start = moving;
			end
			ST_SQ: begin
				root_start = sqx_sts.done;
			end
			ST_OUT: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			dist_q      <= '0;
			armed_q     <= 1'b1;
			low_q       <= 1'b0;
			full_q      <= '0;
			thr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FULL_RANGE: full_q <= cfg_data;
					REG_LOW_THRESH: thr_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			if (state_q == ST_PREP) begin
				if (kind_q) begin
					dist_q  <= '0;
					low_q   <= 1'b0;
					armed_q <= 1'b1;
				end else if (first_fix || moving) begin
					prev_x_q <= x_q;
					prev_y_q <= y_q;
					if (first_fix) begin
						dist_q  <= '0;
						armed_q <= 1'b0;
					end
				end
			end

			if (state_q == ST_ACC) begin
				dist_q <= sat ? '1 : sum_w[DIST_BITS-1:0];
			end

			if (state_q == ST_CHK) begin
				if ($signed(rem_q) < $signed(REM_BITS'(thr_q))) begin
					low_q <= 1'b1;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			x_q    <= pos_x;
			y_q    <= pos_y;
		end
		if (state_q == ST_REM) begin
			rem_q <= REM_BITS'(full_q) - REM_BITS'(dist_q);
		end
		if (out_load) begin
			out_dist_q <= dist_q;
			out_rem_q  <= rem_q;
			out_low_q  <= low_q;
			out_trk_q  <= !armed_q;
		end
	end

	assign cfg_ready          = 1'b1;
	assign out_valid          = out_valid_q;
	assign distance_travelled = out_dist_q;
	assign remaining_range    = $signed(out_rem_q);
	assign low_battery        = out_low_q;
	assign tracking           = out_trk_q;

	`OBE_CHECK(a_armed_dist_zero, armed_q, dist_q == '0, "distance nonzero while armed")
	`OBE_CHECK(a_low_clears_on_recharge, $fell(low_q),
		$past(state_q == ST_PREP && kind_q), "low flag cleared without recharge")
	`OBE_CHECK(a_root_after_squares, root_sts.busy,
		!sqx_sts.busy && !sqy_sts.busy, "square root running beside squarers")
	`OBE_CHECK_NEXT(a_accept_to_prep, accept, state_q == ST_PREP, "accepted request not decoded")

endmodule

### tb/odometry_battery_estimator_core_test.sv
// self-checking testbench for the odometry battery estimator core
`timescale 1ns / 1ps

module odometry_battery_estimator_core_test;
	import obe_pkg::*;

	localparam int COORD_W          = 24;
	localparam int DIST_W           = 32;
	localparam int REM_W            = 33;
	localparam int SETTLE_CYCLES    = 60;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT      = 5000;

	localparam logic KIND_SAMPLE   = 1'b0;
	localparam logic KIND_RECHARGE = 1'b1;

	// indexes the block does not decode, writes to them must be dropped
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	localparam logic [DIST_W-1:0]         DIST_SAT  = '1;
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [REM_W-1:0]  remaining;
		logic              low;
		logic              trk;
	} odo_report_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        kind;
	logic signed [COORD_W-1:0]   pos_x;
	logic signed [COORD_W-1:0]   pos_y;
	logic                        out_valid;
	logic                        out_stall;
	logic [DIST_W-1:0]           distance_travelled;
	logic signed [REM_W-1:0]     remaining_range;
	logic                        low_battery;
	logic                        tracking;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_BITS-1:0]     cfg_index;
	logic [CFG_BITS-1:0]         cfg_data;

	// predictor state
	logic [CFG_BITS-1:0]         full_range_reg;
	logic [CFG_BITS-1:0]         low_thresh_reg;
	logic signed [COORD_W-1:0]   last_x;
	logic signed [COORD_W-1:0]   last_y;
	logic [DIST_W-1:0]           odo_distance;
	logic                        odo_armed;
	logic                        odo_low;

	odo_report_t                 report_q[$];

	logic signed [COORD_W-1:0]   walk_x;
	logic signed [COORD_W-1:0]   walk_y;
	bit                          idle_on;
	bit                          long_hold_req;
	int unsigned                 mismatches;
	int unsigned                 checked;
	int unsigned                 accepted_reqs;
	int unsigned                 recharges;
	int unsigned                 sat_hits;

	odometry_battery_estimator_core #(
		.COORD_BITS(COORD_W),
		.DIST_BITS (DIST_W)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.distance_travelled(distance_travelled),
		.remaining_range   (remaining_range),
		.low_battery       (low_battery),
		.tracking          (tracking),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #2 clk = ~clk;

	// largest r with r*r <= v, built one bit at a time from the top
	function automatic logic [31:0] floor_sqrt(logic [63:0] v);
		logic [31:0] root;
		logic [31:0] cand;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (32'd1 << b);
			if ({32'd0, cand} * {32'd0, cand} <= v)
				root = cand;
		end
		return root;
	endfunction

	function automatic odo_report_t advance_odometry(logic k, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		longint      dx;
		longint      dy;
		longint      remaining;
		logic [63:0] step;
		logic [63:0] total;
		odo_report_t r;
		if (k == KIND_RECHARGE) begin
			odo_distance = '0;
			odo_low      = 1'b0;
			odo_armed    = 1'b1;
		end else begin
			// first sample with both coordinates nonzero starts a new track
			if (odo_armed && x != 0 && y != 0) begin
				last_x       = x;
				last_y       = y;
				odo_distance = '0;
				odo_armed    = 1'b0;
			end
			if (!odo_armed) begin
				dx    = longint'(x) - longint'(last_x);
				dy    = longint'(y) - longint'(last_y);
				step  = {32'd0, floor_sqrt(dx * dx + dy * dy)};
				total = {32'd0, odo_distance} + step;
				odo_distance = (total > {32'd0, DIST_SAT}) ? DIST_SAT : total[DIST_W-1:0];
				last_x = x;
				last_y = y;
			end
			if (longint'(full_range_reg) - longint'(odo_distance) < longint'(low_thresh_reg))
				odo_low = 1'b1;
		end
		remaining   = longint'(full_range_reg) - longint'(odo_distance);
		r.distance  = odo_distance;
		r.remaining = remaining[REM_W-1:0];
		r.low       = odo_low;
		r.trk       = !odo_armed;
		if (odo_distance == DIST_SAT)
			sat_hits++;
		return r;
	endfunction

	// mostly short hops along a path, with jumps, extremes, zero axes and standstill
	function automatic void next_position();
		int delta;
		case ($urandom_range(0, 9))
			0, 1: begin
				walk_x = COORD_W'($urandom);
				walk_y = COORD_W'($urandom);
			end
			2: begin
				walk_x = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
				walk_y = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
			end
			3: begin
				if ($urandom_range(0, 1))
					walk_x = '0;
				else
					walk_y = '0;
			end
			4: ;
			default: begin
				delta  = int'($urandom_range(0, 4095)) - 2048;
				walk_x = COORD_W'(walk_x + delta);
				delta  = int'($urandom_range(0, 4095)) - 2048;
				walk_y = COORD_W'(walk_y + delta);
			end
		endcase
	endfunction

	task automatic send_request(logic k, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		bit taken;
		in_valid <= 1'b1;
		kind     <= k;
		pos_x    <= x;
		pos_y    <= y;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		report_q.push_back(advance_odometry(k, x, y));
		accepted_reqs++;
		if (k == KIND_RECHARGE)
			recharges++;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		case (idx)
			REG_FULL_RANGE: full_range_reg = val;
			REG_LOW_THRESH: low_thresh_reg = val;
			default: ;
		endcase
	endtask

	task automatic configure(logic [CFG_BITS-1:0] full, logic [CFG_BITS-1:0] thr);
		settle();
		write_reg(REG_FULL_RANGE, full);
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		write_reg(REG_LOW_THRESH, thr);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_request(KIND_SAMPLE, 0, 0);
		send_request(KIND_SAMPLE, 0, COORD_MIN);
	endtask

	task automatic test_directed_walk();
		configure(32'd256000, 32'd51200);
		send_request(KIND_SAMPLE, 0, 5);
		send_request(KIND_SAMPLE, -7, 0);
		send_request(KIND_SAMPLE, COORD_MIN, COORD_MAX);
		// diagonal across the whole coordinate range
		send_request(KIND_SAMPLE, COORD_MAX, COORD_MIN);
		send_request(KIND_SAMPLE, 0, 0);
		send_request(KIND_SAMPLE, 0, 0);
		send_request(KIND_SAMPLE, 3, 4);
		send_request(KIND_RECHARGE, -1, -1);
		send_request(KIND_SAMPLE, 0, 9);
		send_request(KIND_SAMPLE, 1, 1);
		send_request(KIND_SAMPLE, 2, 2);
		send_request(KIND_SAMPLE, -1, -1);
	endtask

	task automatic test_low_threshold();
		configure(32'd100, 32'd90);
		send_request(KIND_RECHARGE, 0, 0);
		send_request(KIND_SAMPLE, 10, 10);
		// lands exactly on the threshold, flag stays clear
		send_request(KIND_SAMPLE, 16, 18);
		send_request(KIND_SAMPLE, 16, 19);
		send_request(KIND_SAMPLE, 16, 19);
		send_request(KIND_RECHARGE, 5, 5);
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_SAMPLE, 1, 1);
		send_request(KIND_SAMPLE, 2, 1);
		configure(32'd0, 32'd0);
		send_request(KIND_RECHARGE, 0, 0);
		send_request(KIND_SAMPLE, -1, -1);
		send_request(KIND_SAMPLE, -1, 2);
	endtask

	task automatic test_saturation();
		configure(32'hFFFF_FFFF, 32'd0);
		send_request(KIND_RECHARGE, 0, 0);
		send_request(KIND_SAMPLE, COORD_MIN, COORD_MIN);
		for (int i = 0; i < 190; i++) begin
			if (i % 2 == 0)
				send_request(KIND_SAMPLE, COORD_MAX, COORD_MAX);
			else
				send_request(KIND_SAMPLE, COORD_MIN, COORD_MIN);
		end
	endtask

	task automatic random_items(int unsigned count, int unsigned recharge_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < recharge_pct) begin
				send_request(KIND_RECHARGE, COORD_W'($urandom), COORD_W'($urandom));
			end else begin
				next_position();
				send_request(KIND_SAMPLE, walk_x, walk_y);
			end
		end
	endtask

	task automatic test_random_walk();
		logic [CFG_BITS-1:0] full;
		logic [CFG_BITS-1:0] thr;
		for (int phase = 0; phase < 5; phase++) begin
			full = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
			thr  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, full);
			configure(full, thr);
			random_items(140, 5);
		end
	endtask

	// results held back for a long stretch while requests keep coming
	task automatic test_backpressure();
		configure($urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0004_0000));
		idle_on       = 1'b0;
		long_hold_req = 1'b1;
		random_items(30, 5);
		idle_on = 1'b1;
	endtask

	task automatic test_final_burst();
		configure($urandom, $urandom);
		idle_on = 1'b0;
		random_items(150, 3);
	endtask

	initial begin : result_sink
		int unsigned burst;
		int unsigned hold;
		int unsigned quiet;
		burst = 0;
		hold  = 0;
		quiet = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD_CYCLES;
			end
			if (hold != 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (!idle_on) begin
				out_stall <= 1'b0;
			end else if (burst != 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (quiet != 0) begin
				quiet--;
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 15))
					0, 1: begin
						burst = $urandom_range(0, 7);
						out_stall <= 1'b1;
					end
					2: begin
						quiet = $urandom_range(20, 80);
						out_stall <= 1'b0;
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// outputs are stable between falling edge and the rising edge that takes the result
	always @(negedge clk) begin : result_check
		odo_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (report_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: distance %0d remaining %0d low %0b tracking %0b",
						distance_travelled, remaining_range, low_battery, tracking);
			end else begin
				want = report_q.pop_front();
				checked++;
				if (distance_travelled !== want.distance ||
				    remaining_range !== want.remaining ||
				    low_battery !== want.low || tracking !== want.trk) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch on result %0d (expected/actual): ",
							"distance %0d/%0d remaining %0d/%0d low %0b/%0b tracking %0b/%0b"},
							checked, want.distance, distance_travelled,
							$signed(want.remaining), remaining_range, want.low, low_battery,
							want.trk, tracking);
				end
			end
		end
	end

	initial begin
		int unsigned waited;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= KIND_SAMPLE;
		pos_x     <= '0;
		pos_y     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FULL_RANGE;
		cfg_data  <= '0;
		full_range_reg = '0;
		low_thresh_reg = '0;
		last_x         = '0;
		last_y         = '0;
		odo_distance   = '0;
		odo_armed      = 1'b1;
		odo_low        = 1'b0;
		walk_x         = '0;
		walk_y         = '0;
		idle_on        = 1'b1;
		long_hold_req  = 1'b0;
		mismatches     = 0;
		checked        = 0;
		accepted_reqs  = 0;
		recharges      = 0;
		sat_hits       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_walk();
		test_low_threshold();
		test_saturation();
		test_random_walk();
		test_backpressure();
		test_final_burst();

		in_valid <= 1'b0;
		waited = 0;
		while (report_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += report_q.size();

		$display("run covered %0d requests (%0d recharges) over several range settings",
			accepted_reqs, recharges);
		$display("%0d results compared, %0d with saturated distance, %0d failures",
			checked, sat_hits, mismatches);
		if (mismatches == 0)
			$display("odometry_battery_estimator_core verification clean");
		else
			$display("odometry_battery_estimator_core verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("odometry_battery_estimator_core verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/obe_pkg.sv
rtl/core/obe_sqr.sv
rtl/core/obe_isqrt.sv
rtl/core/odometry_battery_estimator_core.sv
tb/odometry_battery_estimator_core_test.sv
